// File: design/klvl_pkg.sv
// Shared constants and helpers for the keyed linear value learner.
`timescale 1ns / 1ps
`default_nettype none
package klvl_pkg;
   localparam int ITEMS = 64;
   localparam int FEATURES = 16;
   localparam int SLOT_W = (ITEMS > 1) ? $clog2(ITEMS) : 1;
   localparam int FEAT_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;
   localparam int WADDR_W = SLOT_W + FEAT_W;
   localparam int POS_W = $clog2(FEATURES + 1);

   localparam logic [1:0] OP_SCORE = 2'd0;
   localparam logic [1:0] OP_TRAIN = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   // unused code, behaves as score
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam logic [1:0] ST_HIT = 2'd0;
   localparam logic [1:0] ST_NEW = 2'd1;
   localparam logic [1:0] ST_UNKNOWN = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   localparam logic [1:0] CSR_RATE = 2'd0;
   localparam logic [1:0] CSR_LAMBDA = 2'd1;
   localparam logic [1:0] CSR_LIMIT = 2'd2;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
      if (x > 48'sd2147483647) return 32'sh7fffffff;
      if (x < -48'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] c);
      return (c == 32'hffffffff) ? c : c + 32'd1;
   endfunction
endpackage
`default_nettype wire

// File: design/klvl_core.sv
// Sequencer with key search, weight memory, dot product and weight update.
`timescale 1ns / 1ps
`default_nettype none
module klvl_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [1:0]         op,
   input  wire logic [31:0]        item_key,
   input  wire logic signed [15:0] reward,
   input  wire logic [15:0]        rate,
   input  wire logic [15:0]        lambda,
   input  wire logic [14:0]        limit,
   output logic [klvl_pkg::FEAT_W-1:0] fb_idx,
   input  wire logic signed [15:0] fb_val,
   output logic                    busy,
   output logic                    done,
   output logic [1:0]              status,
   output logic [31:0]             q_value,
   output logic [31:0]             error,
   output logic [31:0]             item_trains,
   output logic [31:0]             total_trains
);
   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001, S_SRCH = 7'b0000010, S_DOT = 7'b0000100,
      S_ERR = 7'b0001000, S_UPD = 7'b0010000, S_UPD2 = 7'b0100000,
      S_FIN = 7'b1000000
   } state_type;

   localparam int LAST_SLOT = klvl_pkg::ITEMS - 1;
   localparam int LAST_FEAT = klvl_pkg::FEATURES - 1;

   state_type state_ff, state_in;
   logic [31:0] key_mem [klvl_pkg::ITEMS];
   logic [31:0] cnt_mem [klvl_pkg::ITEMS];
   logic signed [15:0] w_mem [klvl_pkg::ITEMS * klvl_pkg::FEATURES];
   logic [klvl_pkg::ITEMS-1:0] valid_ff;
   logic [31:0] total_ff;

   logic [klvl_pkg::SLOT_W-1:0] scan_ff, slot_ff, free_ff;
   logic hit_ff, free_ok_ff, fresh_ff, train_ff, scan_ph_ff;
   logic [31:0] key_rd_ff, cnt_rd_ff;
   logic signed [15:0] w_rd_ff;
   logic [klvl_pkg::FEAT_W-1:0] idx_ff;
   logic rd_ph_ff;
   logic signed [47:0] acc_ff;
   logic signed [31:0] q_ff, e_ff;
   logic signed [63:0] g_ff;
   logic signed [47:0] d_ff;
   logic [31:0] al_ff;
   logic signed [15:0] wold_ff, f_ff;
   logic [1:0] status_ff;
   logic [31:0] itr_ff;
   logic done_ff;
   logic we;
   logic signed [15:0] wdata, wcur;
   logic signed [39:0] nw;
   logic [klvl_pkg::WADDR_W-1:0] waddr;

   assign waddr = {slot_ff, idx_ff};
   assign wcur = fresh_ff ? 16'sd0 : w_rd_ff;
   assign fb_idx = idx_ff;
   assign busy = (state_ff != S_IDLE);
   assign done = done_ff;
   assign status = status_ff;
   assign q_value = q_ff;
   assign error = e_ff;
   assign item_trains = itr_ff;
   assign total_trains = total_ff;

   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[scan_ff];
      cnt_rd_ff <= cnt_mem[slot_ff];
      w_rd_ff <= w_mem[waddr];
      if (we) w_mem[waddr] <= wdata;
   end

   // new weight: w + floor(g>>28) - floor(d>>32), clamped
   always_comb begin
      nw = 40'(wold_ff) + 40'(g_ff >>> 28) - 40'(d_ff >>> 32);
      if (nw > $signed({25'b0, limit})) nw = $signed({25'b0, limit});
      if (nw < -$signed({25'b0, limit})) nw = -$signed({25'b0, limit});
      wdata = nw[15:0];
      we = (state_ff == S_FIN) && rd_ph_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (start) state_in = (op == klvl_pkg::OP_CLEAR) ? S_FIN : S_SRCH;
         S_SRCH: if (scan_ph_ff && (hit_ff || 32'(scan_ff) == LAST_SLOT)) state_in = S_DOT;
         S_DOT:  if (rd_ph_ff && 32'(idx_ff) == LAST_FEAT) state_in = S_ERR;
         S_ERR:  state_in = (train_ff && (hit_ff || free_ok_ff)) ? S_UPD : S_FIN;
         S_UPD:  state_in = S_UPD2;
         S_UPD2: state_in = S_FIN;
         S_FIN:  state_in = (train_ff && !(32'(idx_ff) == LAST_FEAT)) ? S_UPD : S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         total_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               scan_ff <= '0; scan_ph_ff <= 1'b0; hit_ff <= 1'b0; free_ok_ff <= 1'b0;
               idx_ff <= '0; rd_ph_ff <= 1'b0; acc_ff <= '0; fresh_ff <= 1'b0;
               train_ff <= (op == klvl_pkg::OP_TRAIN);
               status_ff <= klvl_pkg::ST_HIT; q_ff <= '0; e_ff <= '0; itr_ff <= '0;
               if (start && op == klvl_pkg::OP_CLEAR) begin
                  valid_ff <= '0; total_ff <= '0; train_ff <= 1'b0;
               end
            end
            S_SRCH: begin
               // read key, compare next cycle
               scan_ph_ff <= !scan_ph_ff;
               if (scan_ph_ff) begin
                  if (valid_ff[scan_ff] && key_rd_ff == item_key) begin
                     hit_ff <= 1'b1; slot_ff <= scan_ff;
                  end else if (!valid_ff[scan_ff] && !free_ok_ff) begin
                     free_ok_ff <= 1'b1; free_ff <= scan_ff;
                  end
                  if (!(valid_ff[scan_ff] && key_rd_ff == item_key) &&
                      32'(scan_ff) != LAST_SLOT)
                     scan_ff <= scan_ff + klvl_pkg::SLOT_W'(1);
               end
            end
            S_DOT: begin
               if (!hit_ff) begin
                  idx_ff <= idx_ff; rd_ph_ff <= 1'b1;
                  if (!rd_ph_ff && free_ok_ff && train_ff) begin
                     slot_ff <= free_ff; fresh_ff <= 1'b1;
                     valid_ff[free_ff] <= 1'b1; key_mem[free_ff] <= item_key;
                     cnt_mem[free_ff] <= '0;
                  end
                  if (rd_ph_ff) idx_ff <= klvl_pkg::FEAT_W'(LAST_FEAT);
               end else begin
                  rd_ph_ff <= !rd_ph_ff;
                  if (rd_ph_ff) begin
                     acc_ff <= acc_ff + 48'(w_rd_ff * fb_val);
                     if (32'(idx_ff) != LAST_FEAT) idx_ff <= idx_ff + klvl_pkg::FEAT_W'(1);
                  end
               end
            end
            S_ERR: begin
               idx_ff <= '0; rd_ph_ff <= 1'b0;
               if (!hit_ff && !(free_ok_ff && train_ff)) begin
                  train_ff <= 1'b0;
                  status_ff <= train_ff ? klvl_pkg::ST_FULL : klvl_pkg::ST_UNKNOWN;
               end else begin
                  if (!hit_ff) status_ff <= klvl_pkg::ST_NEW;
                  q_ff <= klvl_pkg::sat32(acc_ff >>> 12);
                  itr_ff <= fresh_ff ? 32'd0 : cnt_rd_ff;
                  if (train_ff) begin
                     e_ff <= klvl_pkg::sat32(48'(reward) - 48'(klvl_pkg::sat32(acc_ff >>> 12)));
                     cnt_mem[slot_ff] <= klvl_pkg::sat_inc(fresh_ff ? 32'd0 : cnt_rd_ff);
                     itr_ff <= klvl_pkg::sat_inc(fresh_ff ? 32'd0 : cnt_rd_ff);
                     total_ff <= klvl_pkg::sat_inc(total_ff);
                  end
               end
            end
            S_UPD: begin
               rd_ph_ff <= 1'b0;
               g_ff <= 64'($signed({1'b0, rate}) * e_ff);
               al_ff <= 32'(rate) * 32'(lambda);
               f_ff <= fb_val;
            end
            S_UPD2: begin
               // rate*error split into a signed upper and unsigned lower half
               g_ff <= (64'($signed(g_ff[47:16]) * f_ff) <<< 16) +
                       64'($signed({1'b0, g_ff[15:0]}) * f_ff);
               wold_ff <= wcur;
               d_ff <= 48'($signed({1'b0, al_ff}) * wcur);
               rd_ph_ff <= 1'b1;
            end
            S_FIN: begin
               rd_ph_ff <= 1'b0;
               if (train_ff && 32'(idx_ff) != LAST_FEAT) idx_ff <= idx_ff + klvl_pkg::FEAT_W'(1);
               else done_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

// File: design/keyed_linear_value_learner.sv
// Top level: feature buffer, registers, output register around the core.
// channel | dir | ports
// req     | in  | req_valid/req_ready, op item_key feature_value last_feature reward
// rsp     | out | rsp_valid/rsp_ready, status q_value error item_trains total_trains
// csr     | in  | csr_write, csr_index, csr_data
// Plain elements only fill the feature buffer. A closing element other than a clear runs
// a key search, reading the key memory slot by slot, then a dot product over the weights
// on a hit, and if training with a slot, an update of each weight in S_UPD, S_UPD2, S_FIN.
// Reset is synchronous; the request side stalls while the core works or a result waits.
`timescale 1ns / 1ps
`default_nettype none
module keyed_linear_value_learner (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [31:0] req_item_key,
   input  wire logic signed [15:0] req_feature_value,
   input  wire logic        req_last_feature,
   input  wire logic signed [15:0] req_reward,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic signed [31:0] rsp_q_value,
   output logic signed [31:0] rsp_error,
   output logic [31:0]      rsp_item_trains,
   output logic [31:0]      rsp_total_trains,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   logic [15:0] rate_ff, lambda_ff;
   logic [14:0] limit_ff;
   logic signed [15:0] fbuf_ff [klvl_pkg::FEATURES];
   logic [klvl_pkg::POS_W-1:0] pos_ff;
   logic [1:0] op_ff;
   logic [31:0] key_ff;
   logic signed [15:0] rew_ff;
   logic start_ff, busy, done, take;
   logic [klvl_pkg::FEAT_W-1:0] fb_idx;
   logic [1:0] c_status;
   logic [31:0] c_q, c_e, c_itr, c_tot;

   // hold off while the core is busy or starting, a result waits, or the buffer is cleared
   assign req_ready = !busy && !start_ff && !rsp_valid && !done;
   assign take = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= 16'd655; lambda_ff <= 16'd66; limit_ff <= 15'd20480;
         pos_ff <= '0; start_ff <= 1'b0; rsp_valid <= 1'b0;
         for (int i = 0; i < klvl_pkg::FEATURES; i++) fbuf_ff[i] <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               klvl_pkg::CSR_RATE:   rate_ff <= csr_data;
               klvl_pkg::CSR_LAMBDA: lambda_ff <= csr_data;
               klvl_pkg::CSR_LIMIT:  limit_ff <= csr_data[14:0];
               default: ;
            endcase
         end
         start_ff <= 1'b0;
         if (take) begin
            if (32'(pos_ff) < klvl_pkg::FEATURES) begin
               fbuf_ff[pos_ff[klvl_pkg::FEAT_W-1:0]] <= req_feature_value;
               pos_ff <= pos_ff + klvl_pkg::POS_W'(1);
            end
            if (req_last_feature) begin
               start_ff <= 1'b1; op_ff <= req_op; key_ff <= req_item_key;
               rew_ff <= req_reward;
            end
         end
         if (done) begin
            rsp_valid <= 1'b1; rsp_status <= c_status; rsp_q_value <= c_q;
            rsp_error <= c_e; rsp_item_trains <= c_itr; rsp_total_trains <= c_tot;
            pos_ff <= '0;
            for (int i = 0; i < klvl_pkg::FEATURES; i++) fbuf_ff[i] <= '0;
         end else if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      end
   end

   klvl_core u_core (
      .clock(clock), .reset(reset), .start(start_ff), .op(op_ff), .item_key(key_ff),
      .reward(rew_ff), .rate(rate_ff), .lambda(lambda_ff), .limit(limit_ff),
      .fb_idx(fb_idx), .fb_val(fbuf_ff[fb_idx]), .busy(busy), .done(done),
      .status(c_status), .q_value(c_q), .error(c_e), .item_trains(c_itr),
      .total_trains(c_tot)
   );
endmodule
`default_nettype wire
